FILE: rtl/core/stcs_pkg.sv
// stcs_pkg: shared types, constants and helper functions of the square tone channel
`timescale 1ns / 1ps

package stcs_pkg;

  localparam int FREQ_W   = 11;
  localparam int PERIOD_W = 13;
  localparam int LEN_W    = 7;

  localparam int LENGTH_BIT_DEF   = 13;
  localparam int ENVELOPE_BIT_DEF = 15;
  localparam int SWEEP_BIT_DEF    = 14;

  localparam logic [LEN_W-1:0] LENGTH_FULL      = 7'd64;
  localparam logic [LEN_W-1:0] LENGTH_FULL_LESS = 7'd63;
  localparam logic [3:0]       VOLUME_MAX       = 4'd15;

  // bit n of a row is step n of the duty pattern
  localparam logic [7:0] DUTY_TABLE [4] = '{
    8'b1000_0000,
    8'b1000_0001,
    8'b1110_0001,
    8'b0111_1110
  };

  typedef enum logic [2:0] {
    REG_SWEEP    = 3'd0,
    REG_LEN_DUTY = 3'd1,
    REG_ENVELOPE = 3'd2,
    REG_FREQ_LO  = 3'd3,
    REG_CONTROL  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        mode;
    logic [2:0]  reg_index;
    logic [7:0]  write_data;
    logic [15:0] seq_value;
  } item_t;

  typedef struct packed {
    logic [3:0]        sample;
    logic              channel_on;
    logic [FREQ_W-1:0] cur_frequency;
  } result_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              over;
  } sweep_t;

  function automatic sweep_t sweep_calc(input logic [FREQ_W-1:0] shadow,
                                        input logic [6:0] sweep);
    logic [FREQ_W:0] delta;
    logic [FREQ_W:0] sum;
    sweep_t          res;
    delta = {1'b0, shadow >> sweep[2:0]};
    if (sweep[3]) begin
      sum = {1'b0, shadow} - delta;
    end else begin
      sum = {1'b0, shadow} + delta;
    end
    res.freq = sum[FREQ_W-1:0];
    res.over = sum[FREQ_W];
    return res;
  endfunction

  function automatic logic [PERIOD_W-1:0] timer_reload(input logic [FREQ_W-1:0] freq);
    logic [FREQ_W:0] diff;
    diff = 12'd2048 - {1'b0, freq};
    return {diff, 1'b0};
  endfunction

endpackage

FILE: rtl/core/stcs_chan.sv
// stcs_chan: channel state registers and the per-beat update of sweep, timer, length, envelope
`timescale 1ns / 1ps

module stcs_chan #(
  parameter int LENGTH_BIT   = stcs_pkg::LENGTH_BIT_DEF,
  parameter int ENVELOPE_BIT = stcs_pkg::ENVELOPE_BIT_DEF,
  parameter int SWEEP_BIT    = stcs_pkg::SWEEP_BIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  stcs_pkg::item_t   item,
  output stcs_pkg::result_t res_nxt
);

  logic [6:0]                     sweep_reg_r, sweep_reg_nxt;
  logic [1:0]                     duty_sel_r, duty_sel_nxt;
  logic [7:0]                     env_reg_r, env_reg_nxt;
  logic [stcs_pkg::FREQ_W-1:0]    freq_r, freq_nxt;
  logic                           len_en_r, len_en_nxt;
  logic [stcs_pkg::LEN_W-1:0]     len_cnt_r, len_cnt_nxt;
  logic [stcs_pkg::PERIOD_W-1:0]  period_r, period_nxt;
  logic [2:0]                     duty_step_r, duty_step_nxt;
  logic [3:0]                     vol_r, vol_nxt;
  logic [2:0]                     env_cnt_r, env_cnt_nxt;
  logic                           env_act_r, env_act_nxt;
  logic [stcs_pkg::FREQ_W-1:0]    shadow_r, shadow_nxt;
  logic [3:0]                     sweep_cnt_r, sweep_cnt_nxt;
  logic                           sweep_act_r, sweep_act_nxt;
  logic                           neg_used_r, neg_used_nxt;
  logic [2:0]                     prev_r, prev_nxt;
  logic                           enabled_r, enabled_nxt;

  stcs_pkg::sweep_t sc_a;
  stcs_pkg::sweep_t sc_b;
  logic             ln, ev, sw;
  logic [7:0]       wd;

  assign ln = item.seq_value[LENGTH_BIT];
  assign ev = item.seq_value[ENVELOPE_BIT];
  assign sw = item.seq_value[SWEEP_BIT];
  assign wd = item.write_data;

  always_comb begin
    sweep_reg_nxt = sweep_reg_r;
    duty_sel_nxt  = duty_sel_r;
    env_reg_nxt   = env_reg_r;
    freq_nxt      = freq_r;
    len_en_nxt    = len_en_r;
    len_cnt_nxt   = len_cnt_r;
    period_nxt    = period_r;
    duty_step_nxt = duty_step_r;
    vol_nxt       = vol_r;
    env_cnt_nxt   = env_cnt_r;
    env_act_nxt   = env_act_r;
    shadow_nxt    = shadow_r;
    sweep_cnt_nxt = sweep_cnt_r;
    sweep_act_nxt = sweep_act_r;
    neg_used_nxt  = neg_used_r;
    prev_nxt      = prev_r;
    enabled_nxt   = enabled_r;
    sc_a          = '0;
    sc_b          = '0;

    if (!item.mode) begin
      // sweep unit
      if (sweep_act_r && !sw && prev_r[2]) begin
        sweep_cnt_nxt = sweep_cnt_r - 4'd1;
        if (sweep_cnt_nxt == 4'd0) begin
          sc_a = stcs_pkg::sweep_calc(shadow_r, sweep_reg_r);
          if (sweep_reg_r[3]) begin
            neg_used_nxt = 1'b1;
          end
          if (sc_a.over) begin
            sweep_act_nxt = 1'b0;
            enabled_nxt   = 1'b0;
          end else begin
            shadow_nxt = sc_a.freq;
            freq_nxt   = sc_a.freq;
            sc_b = stcs_pkg::sweep_calc(sc_a.freq, sweep_reg_r);
            if (sc_b.over) begin
              sweep_act_nxt = 1'b0;
              enabled_nxt   = 1'b0;
            end
          end
          sweep_cnt_nxt = {1'b0, sweep_reg_r[6:4]} + 4'd1;
        end
      end
      // period timer
      if (period_r == '0) begin
        duty_step_nxt = duty_step_r + 3'd1;
        period_nxt    = stcs_pkg::timer_reload(freq_nxt);
      end else begin
        period_nxt = period_r - 13'd1;
      end
      // length counter
      if (len_en_r && len_cnt_r != '0 && !ln && prev_r[0]) begin
        len_cnt_nxt = len_cnt_r - 7'd1;
        if (len_cnt_nxt == '0) begin
          enabled_nxt = 1'b0;
        end
      end
      // envelope
      if (env_act_r && !ev && prev_r[1]) begin
        env_cnt_nxt = env_cnt_r - 3'd1;
        if (env_cnt_nxt == 3'd0) begin
          if (!env_reg_r[3]) begin
            if (vol_r != 4'd0) begin
              vol_nxt = vol_r - 4'd1;
            end
            if (vol_nxt == 4'd0) begin
              env_act_nxt = 1'b0;
            end
          end else begin
            if (vol_r != stcs_pkg::VOLUME_MAX) begin
              vol_nxt = vol_r + 4'd1;
            end
            if (vol_nxt == stcs_pkg::VOLUME_MAX) begin
              env_act_nxt = 1'b0;
            end
          end
          env_cnt_nxt = env_reg_r[2:0];
        end
      end
      prev_nxt = {sw, ev, ln};
    end else begin
      case (stcs_pkg::reg_idx_t'(item.reg_index))
        stcs_pkg::REG_SWEEP: begin
          sweep_reg_nxt = wd[6:0];
          if (wd[6:4] == 3'd0 || wd[2:0] == 3'd0 || (!wd[3] && neg_used_r)) begin
            sweep_act_nxt = 1'b0;
          end
        end
        stcs_pkg::REG_LEN_DUTY: begin
          duty_sel_nxt = wd[7:6];
          len_cnt_nxt  = stcs_pkg::LENGTH_FULL - {1'b0, wd[5:0]};
        end
        stcs_pkg::REG_ENVELOPE: begin
          env_reg_nxt = wd;
          if (wd[7:4] == 4'd0) begin
            enabled_nxt = 1'b0;
          end
        end
        stcs_pkg::REG_FREQ_LO: begin
          freq_nxt = {freq_r[10:8], wd};
        end
        stcs_pkg::REG_CONTROL: begin
          freq_nxt   = {wd[2:0], freq_r[7:0]};
          len_en_nxt = wd[6];
          // extra length clock when enabling in the first half of a length period
          if (!ln && !len_en_r && wd[6] && len_cnt_r != '0) begin
            len_cnt_nxt = len_cnt_r - 7'd1;
            if (len_cnt_nxt == '0) begin
              enabled_nxt = 1'b0;
            end
          end
          if (wd[7]) begin
            enabled_nxt   = 1'b1;
            period_nxt    = stcs_pkg::timer_reload(freq_nxt);
            shadow_nxt    = freq_nxt;
            sweep_cnt_nxt = {1'b0, sweep_reg_r[6:4]};
            sweep_act_nxt = (sweep_reg_r[6:4] != 3'd0) && (sweep_reg_r[2:0] != 3'd0);
            if (sweep_reg_r[2:0] != 3'd0) begin
              sc_a = stcs_pkg::sweep_calc(freq_nxt, sweep_reg_r);
              if (sc_a.over) begin
                sweep_act_nxt = 1'b0;
                enabled_nxt   = 1'b0;
              end
            end
            neg_used_nxt = 1'b0;
            vol_nxt      = env_reg_r[7:4];
            env_cnt_nxt  = env_reg_r[2:0];
            env_act_nxt  = (env_reg_r[2:0] != 3'd0) &&
                           !((!env_reg_r[3] && env_reg_r[7:4] == 4'd0) ||
                             (env_reg_r[3] && env_reg_r[7:4] == stcs_pkg::VOLUME_MAX));
            if (len_cnt_nxt == '0) begin
              len_cnt_nxt = stcs_pkg::LENGTH_FULL;
              if (!ln && wd[6]) begin
                len_cnt_nxt = stcs_pkg::LENGTH_FULL_LESS;
              end
            end
            if (env_reg_r[7:4] == 4'd0) begin
              enabled_nxt = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_nxt.sample        = stcs_pkg::DUTY_TABLE[duty_sel_nxt][duty_step_nxt] ? vol_nxt : 4'd0;
    res_nxt.channel_on    = enabled_nxt;
    res_nxt.cur_frequency = freq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_reg_r <= '0;
      duty_sel_r  <= '0;
      env_reg_r   <= '0;
      freq_r      <= '0;
      len_en_r    <= 1'b0;
      len_cnt_r   <= '0;
      period_r    <= '0;
      duty_step_r <= '0;
      vol_r       <= '0;
      env_cnt_r   <= '0;
      env_act_r   <= 1'b0;
      shadow_r    <= '0;
      sweep_cnt_r <= '0;
      sweep_act_r <= 1'b0;
      neg_used_r  <= 1'b0;
      prev_r      <= '0;
      enabled_r   <= 1'b0;
    end else if (en) begin
      sweep_reg_r <= sweep_reg_nxt;
      duty_sel_r  <= duty_sel_nxt;
      env_reg_r   <= env_reg_nxt;
      freq_r      <= freq_nxt;
      len_en_r    <= len_en_nxt;
      len_cnt_r   <= len_cnt_nxt;
      period_r    <= period_nxt;
      duty_step_r <= duty_step_nxt;
      vol_r       <= vol_nxt;
      env_cnt_r   <= env_cnt_nxt;
      env_act_r   <= env_act_nxt;
      shadow_r    <= shadow_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      sweep_act_r <= sweep_act_nxt;
      neg_used_r  <= neg_used_nxt;
      prev_r      <= prev_nxt;
      enabled_r   <= enabled_nxt;
    end
  end

endmodule

FILE: rtl/core/square_tone_channel_with_sweep_unit.sv
// square_tone_channel_with_sweep_unit: top level with input beat register and result register
//
// usage
//   each input beat is either one machine tick (in_mode = 0) or a write of
//   in_write_data to channel register in_reg_index (in_mode = 1); in_seq_value
//   carries the frame sequencer value whose falling bits clock sweep, length
//   and envelope
//   every input beat yields exactly one result beat: sample, channel_on and
//   cur_frequency as they stand after that beat has been applied
//   a beat passes through the input register, then through the channel update
//   into the result register; throughput is one beat per cycle while out_stall
//   does not hold the result; the whole update of one beat is a single pass
//   through the channel logic, so a beat may follow in the next cycle
//   in_stall rises only while both the input register and the result register
//   are full and out_stall holds the result; a held result does not change
//   reset (rst_n low, synchronous) clears all channel state and empties both
//   registers; the block is ready for a beat in the first cycle after reset
`timescale 1ns / 1ps

module square_tone_channel_with_sweep_unit #(
  parameter int LENGTH_BIT   = stcs_pkg::LENGTH_BIT_DEF,
  parameter int ENVELOPE_BIT = stcs_pkg::ENVELOPE_BIT_DEF,
  parameter int SWEEP_BIT    = stcs_pkg::SWEEP_BIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [2:0]                  in_reg_index,
  input  logic [7:0]                  in_write_data,
  input  logic [15:0]                 in_seq_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [3:0]                  out_sample,
  output logic                        out_channel_on,
  output logic [stcs_pkg::FREQ_W-1:0] out_cur_frequency
);

  logic              s1_valid_r;
  stcs_pkg::item_t   s1_item_r;
  logic              out_valid_r;
  stcs_pkg::result_t out_res_r;
  stcs_pkg::result_t res_nxt;
  logic              out_free;
  logic              advance;
  logic              in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  stcs_chan #(
    .LENGTH_BIT   (LENGTH_BIT),
    .ENVELOPE_BIT (ENVELOPE_BIT),
    .SWEEP_BIT    (SWEEP_BIT)
  ) u_chan (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .item    (s1_item_r),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= '{mode: in_mode, reg_index: in_reg_index,
                     write_data: in_write_data, seq_value: in_seq_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample        = out_res_r.sample;
  assign out_channel_on    = out_res_r.channel_on;
  assign out_cur_frequency = out_res_r.cur_frequency;

  // input side backs up only when both stages are occupied
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("in_stall raised with a free stage");

  // a beat leaving the input register always lands in the result register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced beat lost before result register");

  // a held result keeps the pending input beat in place
  a_hold_keeps_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("pending input beat changed while result held");

endmodule
